// ----- src/pcrc_pkg.sv -----
// pcrc_pkg: shared constants, register indexes and types for the pulse channel
// remap and clamp unit. No dependencies; every other file takes names from here.
`default_nettype none

package pcrc_pkg;

   localparam int PW_WIDTH        = 15;
   localparam int SLOT_WIDTH      = 4;
   localparam int POS_WIDTH       = 5;
   localparam int ORDER_WIDTH     = 32;
   localparam int NIB_WIDTH       = 4;
   localparam int PROD_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int SLOTS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int BITS_PER_STEP   = 2;
   localparam int DIV_STEPS       = PROD_WIDTH / BITS_PER_STEP;

   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PULSE_LOW   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PULSE_HIGH  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_LOW     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_FLOOR   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_CEILING = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOT_ORDER  = 3'd6;

   // Reset values
   localparam logic [PW_WIDTH-1:0]    RST_PULSE_LOW   = 15'd1800;
   localparam logic [PW_WIDTH-1:0]    RST_PULSE_HIGH  = 15'd4200;
   localparam logic [PW_WIDTH-1:0]    RST_OUT_LOW     = 15'd204;
   localparam logic [PW_WIDTH-1:0]    RST_OUT_HIGH    = 15'd1844;
   localparam logic [PW_WIDTH-1:0]    RST_OUT_FLOOR   = 15'd0;
   localparam logic [PW_WIDTH-1:0]    RST_OUT_CEILING = 15'd2047;
   localparam logic [ORDER_WIDTH-1:0] RST_SLOT_ORDER  = 32'd0;

   typedef struct packed {
      logic [PW_WIDTH-1:0] pulse_low;
      logic [PW_WIDTH-1:0] pulse_high;
      logic [PW_WIDTH-1:0] out_low;
      logic [PW_WIDTH-1:0] out_high;
      logic [PW_WIDTH-1:0] out_floor;
      logic [PW_WIDTH-1:0] out_ceiling;
   } map_cfg_type;

   // One classified item waiting for the divider
   typedef struct packed {
      logic [SLOT_WIDTH-1:0]        dest_slot;
      logic                         dropped;
      logic                         frame_done;
      logic signed [PROD_WIDTH-1:0] product;
   } queue_entry_type;

endpackage

`default_nettype wire

// ----- src/pcrc_if.sv -----
// Channel interfaces of the pulse channel remap and clamp unit: item input,
// result output and register write. Depends on pcrc_pkg for field widths.
`default_nettype none

interface pcrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [pcrc_pkg::PW_WIDTH-1:0] pulse_width;
   logic                          frame_end;
   modport source (output valid, pulse_width, frame_end, input ready);
   modport sink   (input valid, pulse_width, frame_end, output ready);
endinterface

interface pcrc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pcrc_pkg::SLOT_WIDTH-1:0] dest_slot;
   logic [pcrc_pkg::PW_WIDTH-1:0]   slot_value;
   logic                            dropped;
   logic                            frame_done;
   modport source (output valid, dest_slot, slot_value, dropped, frame_done, input ready);
   modport sink   (input valid, dest_slot, slot_value, dropped, frame_done, output ready);
endinterface

interface pcrc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [pcrc_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [pcrc_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/pcrc_front.sv -----
// pcrc_front: accepts items, picks the destination slot from the order word
// and forms the mapping product. Depends on pcrc_pkg and pcrc_if.
`default_nettype none

module pcrc_front #(
   parameter int SLOTS = pcrc_pkg::SLOTS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   pcrc_req_if.sink                             req_if,
   input  wire pcrc_pkg::map_cfg_type           map_cfg,
   input  wire [pcrc_pkg::ORDER_WIDTH-1:0]      slot_order,
   input  wire                                  queue_full,
   output logic                                 push,
   output pcrc_pkg::queue_entry_type            push_entry
);

   localparam int PW  = pcrc_pkg::PW_WIDTH;
   localparam int OW  = pcrc_pkg::ORDER_WIDTH;
   localparam int NW  = pcrc_pkg::NIB_WIDTH;
   localparam int PSW = pcrc_pkg::POS_WIDTH;

   logic [PSW-1:0]       position_ff, position_in;
   logic [OW-1:0]        order_left_ff, order_left_in;
   logic [OW-1:0]        order_cur;
   logic [NW-1:0]        nib;
   logic [PSW-1:0]       dest;
   logic                 drop;
   logic signed [PW:0]   dx, dy;

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   // Reload the order word at frame start
   assign order_cur = (position_ff == '0) ? slot_order : order_left_ff;
   assign nib       = order_cur[OW-1 -: NW];
   assign dest      = (nib != '0) ? (PSW'(nib) - PSW'(1)) : position_ff;
   assign drop      = (dest >= PSW'(SLOTS));

   assign dx = $signed({1'b0, req_if.pulse_width}) - $signed({1'b0, map_cfg.pulse_low});
   assign dy = $signed({1'b0, map_cfg.out_high}) - $signed({1'b0, map_cfg.out_low});

   always_comb begin
      push_entry.dest_slot  = drop ? '0 : dest[pcrc_pkg::SLOT_WIDTH-1:0];
      push_entry.dropped    = drop;
      push_entry.frame_done = req_if.frame_end;
      push_entry.product    = dx * dy;
   end

   always_comb begin
      position_in   = position_ff;
      order_left_in = order_left_ff;
      if (push) begin
         order_left_in = order_cur << NW;
         if (req_if.frame_end) begin
            position_in = '0;
         end else if (position_ff != pcrc_pkg::POS_MAX) begin
            position_in = position_ff + PSW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         order_left_ff <= '0;
      end else begin
         position_ff   <= position_in;
         order_left_ff <= order_left_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/pcrc_queue.sv -----
// pcrc_queue: short flip-flop queue of classified items between front and back.
// Depends on pcrc_pkg.
`default_nettype none

module pcrc_queue (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            push,
   input  wire pcrc_pkg::queue_entry_type push_entry,
   output logic                           full,
   input  wire                            pop,
   output pcrc_pkg::queue_entry_type      pop_entry,
   output logic                           empty
);

   localparam int DEPTH = pcrc_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   pcrc_pkg::queue_entry_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/pcrc_back.sv -----
// pcrc_back: iterative signed divider, offset, clamp and result register.
// Depends on pcrc_pkg and pcrc_if.
`default_nettype none

module pcrc_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wire pcrc_pkg::map_cfg_type     map_cfg,
   input  wire                            queue_empty,
   input  wire pcrc_pkg::queue_entry_type pop_entry,
   output logic                           pop,
   pcrc_rsp_if.source                     rsp_if
);

   localparam int PW  = pcrc_pkg::PW_WIDTH;
   localparam int QW  = pcrc_pkg::PROD_WIDTH;
   localparam int BPS = pcrc_pkg::BITS_PER_STEP;
   localparam int NST = pcrc_pkg::DIV_STEPS;
   localparam int CNW = (NST > 1) ? $clog2(NST) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [CNW-1:0]        cnt_ff, cnt_in;
   logic [PW:0]           rem_ff, rem_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [PW-1:0]         dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;
   logic                  zden_ff, zden_in;
   logic [pcrc_pkg::SLOT_WIDTH-1:0] slot_ff, slot_in;
   logic                  drop_ff, drop_in;
   logic                  fdone_ff, fdone_in;

   logic                  out_valid_ff, out_valid_in;
   logic [pcrc_pkg::SLOT_WIDTH-1:0] out_slot_ff, out_slot_in;
   logic [PW-1:0]         out_value_ff, out_value_in;
   logic                  out_drop_ff, out_drop_in;
   logic                  out_fdone_ff, out_fdone_in;

   logic signed [PW:0]    den;
   logic [QW-1:0]         prod_mag;
   logic [PW:0]           step_rem;
   logic [QW-1:0]         step_quo;
   logic [PW:0]           q16;
   logic [PW:0]           sum;
   logic [PW-1:0]         clamped;
   logic                  out_free;

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.dest_slot  = out_slot_ff;
   assign rsp_if.slot_value = out_value_ff;
   assign rsp_if.dropped    = out_drop_ff;
   assign rsp_if.frame_done = out_fdone_ff;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign pop      = (state_ff == ST_IDLE) && !queue_empty;

   assign den      = $signed({1'b0, map_cfg.pulse_high}) - $signed({1'b0, map_cfg.pulse_low});
   assign prod_mag = pop_entry.product[QW-1] ? QW'(-pop_entry.product)
                                             : QW'(pop_entry.product);

   // Restoring division, a few quotient bits per cycle
   always_comb begin
      logic [PW:0] trial;
      logic        qbit;
      step_rem = rem_ff;
      step_quo = quo_ff;
      for (int i = 0; i < BPS; i++) begin
         trial = {step_rem[PW-1:0], step_quo[QW-1]};
         qbit  = (trial >= {1'b0, dvs_ff});
         step_rem = qbit ? (trial - {1'b0, dvs_ff}) : trial;
         step_quo = {step_quo[QW-2:0], qbit};
      end
   end

   // Sign, offset and clamp on the low 16 quotient bits
   always_comb begin
      q16 = '0;
      if (!zden_ff) begin
         q16 = neg_ff ? (PW+1)'(-quo_ff[PW:0]) : quo_ff[PW:0];
      end
      sum = q16 + {1'b0, map_cfg.out_low};
      if (sum[PW]) begin
         clamped = map_cfg.out_floor;
      end else if (sum[PW-1:0] > map_cfg.out_ceiling) begin
         clamped = map_cfg.out_ceiling;
      end else begin
         clamped = sum[PW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      zden_in      = zden_ff;
      slot_in      = slot_ff;
      drop_in      = drop_ff;
      fdone_in     = fdone_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_slot_in  = out_slot_ff;
      out_value_in = out_value_ff;
      out_drop_in  = out_drop_ff;
      out_fdone_in = out_fdone_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rem_in   = '0;
               quo_in   = prod_mag;
               dvs_in   = den[PW] ? PW'(-den) : PW'(den);
               neg_in   = pop_entry.product[QW-1] ^ den[PW];
               zden_in  = (den == '0);
               slot_in  = pop_entry.dest_slot;
               drop_in  = pop_entry.dropped;
               fdone_in = pop_entry.frame_done;
               cnt_in   = CNW'(NST - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff - CNW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_slot_in  = slot_ff;
               out_value_in = clamped;
               out_drop_in  = drop_ff;
               out_fdone_in = fdone_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      neg_ff       <= neg_in;
      zden_ff      <= zden_in;
      slot_ff      <= slot_in;
      drop_ff      <= drop_in;
      fdone_ff     <= fdone_in;
      out_slot_ff  <= out_slot_in;
      out_value_ff <= out_value_in;
      out_drop_ff  <= out_drop_in;
      out_fdone_ff <= out_fdone_in;
   end

endmodule

`default_nettype wire

// ----- src/pulse_channel_remap_clamp_unit.sv -----
// Path from req transfer to rsp valid: queue write at the transfer, pop into the
// idle divider, divider steps at 2 quotient bits each, then a finish into the result
// register once it is free. The shared iterative divider holds one item at a time.
// Two classified items can wait in the queue while the divider is busy.
// Reset (synchronous, active high) clears position, order word, queue, divider state
// machine and result valid, and loads every config register with its default.
`default_nettype none

module pulse_channel_remap_clamp_unit #(
   parameter int SLOTS = pcrc_pkg::SLOTS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   pcrc_req_if.sink    req_if,
   pcrc_rsp_if.source  rsp_if,
   pcrc_csr_if.sink    csr_if
);

   localparam int PW = pcrc_pkg::PW_WIDTH;

   // Mapping and clamp registers, plus the slot order word
   pcrc_pkg::map_cfg_type                 map_cfg_ff, map_cfg_in;
   logic [pcrc_pkg::ORDER_WIDTH-1:0]      slot_order_ff, slot_order_in;

   logic                                  push;
   pcrc_pkg::queue_entry_type             push_entry;
   logic                                  queue_full;
   logic                                  pop;
   pcrc_pkg::queue_entry_type             pop_entry;
   logic                                  queue_empty;
   logic                                  csr_write;

   // Register writes are always accepted
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   // Decode the register index; unknown indexes drop the write
   always_comb begin
      map_cfg_in    = map_cfg_ff;
      slot_order_in = slot_order_ff;
      if (csr_write) begin
         unique case (csr_if.index)
            pcrc_pkg::REG_PULSE_LOW:   map_cfg_in.pulse_low   = csr_if.data[PW-1:0];
            pcrc_pkg::REG_PULSE_HIGH:  map_cfg_in.pulse_high  = csr_if.data[PW-1:0];
            pcrc_pkg::REG_OUT_LOW:     map_cfg_in.out_low     = csr_if.data[PW-1:0];
            pcrc_pkg::REG_OUT_HIGH:    map_cfg_in.out_high    = csr_if.data[PW-1:0];
            pcrc_pkg::REG_OUT_FLOOR:   map_cfg_in.out_floor   = csr_if.data[PW-1:0];
            pcrc_pkg::REG_OUT_CEILING: map_cfg_in.out_ceiling = csr_if.data[PW-1:0];
            pcrc_pkg::REG_SLOT_ORDER:  slot_order_in          = csr_if.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cfg_ff.pulse_low   <= pcrc_pkg::RST_PULSE_LOW;
         map_cfg_ff.pulse_high  <= pcrc_pkg::RST_PULSE_HIGH;
         map_cfg_ff.out_low     <= pcrc_pkg::RST_OUT_LOW;
         map_cfg_ff.out_high    <= pcrc_pkg::RST_OUT_HIGH;
         map_cfg_ff.out_floor   <= pcrc_pkg::RST_OUT_FLOOR;
         map_cfg_ff.out_ceiling <= pcrc_pkg::RST_OUT_CEILING;
         slot_order_ff          <= pcrc_pkg::RST_SLOT_ORDER;
      end else begin
         map_cfg_ff    <= map_cfg_in;
         slot_order_ff <= slot_order_in;
      end
   end

   // Front: take the transfer, pick the slot, form (width - low) * (out_high - out_low)
   pcrc_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .map_cfg    (map_cfg_ff),
      .slot_order (slot_order_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Hold classified items until the divider frees up
   pcrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   // Back: divide by the input span, add the low point, clamp, present result
   pcrc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .map_cfg     (map_cfg_ff),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire
